@@ hdl/fmv_pkg.sv @@
package fmv_pkg;

   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_BITS = $clog2(SINE_ENTRIES);
   localparam int PHASE_BITS = 32;
   localparam int SAMPLE_RATE = 48000;

   localparam int NOTE_COUNT = 128;
   localparam int SINE_W = 16;
   localparam int MAG_BITS = 15;
   localparam int DEPTH_BITS = 16;
   localparam int RATIO_BITS = 16;
   localparam int RATIO_FRAC = 12;
   localparam int RATIO_ROUND = 2048;
   localparam int OFF_BITS = DEPTH_BITS + MAG_BITS;
   localparam int DEPTH_SHIFT = 31;

   // amplitude * |sine| / 127, rounded half up, via reciprocal multiply
   localparam int AMP_BITS = 7;
   localparam int AMP_FULL = 127;
   localparam int AMP_ROUND = 63;
   localparam int PROD_BITS = 22;
   localparam int QUOT_BITS = 15;
   localparam int DIV_MUL = 66052;
   localparam int DIV_MUL_BITS = 17;
   localparam int DIV_SHIFT = 23;
   localparam int DIV_BITS = PROD_BITS + DIV_MUL_BITS;

   // phase step = freq_q16 * 2^PHASE_BITS / (SAMPLE_RATE * 2^16), half up
   localparam logic [63:0] STEP_DEN = 64'(SAMPLE_RATE) << 16;
   localparam logic [63:0] STEP_HALF = STEP_DEN >> 1;

   localparam logic [RATIO_BITS-1:0] MOD_RATIO_RESET = 16'd4915;
   localparam logic [DEPTH_BITS-1:0] MOD_DEPTH_RESET = 16'd585;

   localparam logic [1:0] CSR_MOD_RATIO = 2'd0;
   localparam logic [1:0] CSR_MOD_DEPTH = 2'd1;

   typedef logic [PHASE_BITS-1:0] phase_type;
   typedef logic signed [SINE_W-1:0] sine_type;
   typedef sine_type sine_table_type [SINE_ENTRIES];
   typedef phase_type step_table_type [NOTE_COUNT];

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_NOTE_ON  = 2'd1,
      CMD_NOTE_OFF = 2'd2,
      CMD_END      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      VA_CAR_PHASE = 2'd0,
      VA_MOD_PHASE = 2'd1,
      VA_CAR_STEP  = 2'd2,
      VA_MOD_STEP  = 2'd3
   } voice_addr_type;

   localparam int VOICE_WORDS = 4;

   typedef enum logic [1:0] {
      WD_STEP     = 2'd0,
      WD_MOD_STEP = 2'd1,
      WD_ZERO     = 2'd2,
      WD_SUM      = 2'd3
   } wdata_sel_type;

   typedef enum logic {
      ROM_MOD = 1'b0,
      ROM_CAR = 1'b1
   } rom_sel_type;

   typedef struct packed {
      voice_addr_type rd_addr;
      logic           wr_en;
      voice_addr_type wr_addr;
      wdata_sel_type  wr_sel;
      rom_sel_type    rom_sel;
      logic           ld_mp;
      logic           ld_mix;
      logic           ld_prod;
      logic           ld_quot;
      logic           ld_step;
   } ctrl_type;

   // notes 120..131 in Hz, Q16.16
   localparam logic [31:0] TOP_OCTAVE [12] = '{
      32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
      32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
      32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748354
   };

   // sin(pi/2 * x), x and result in Q30
   function automatic logic [63:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t = 64'd85569278 - ((x2 * 64'd4858467) >> 30);
      t = 64'd693598671 - ((x2 * t) >> 30);
      t = 64'd1686629713 - ((x2 * t) >> 30);
      return (x * t) >> 30;
   endfunction

   // shift-subtract quotient, used only while building tables
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0] u;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] v;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         u = 64'(i) * 64'd4;
         q = u >> SINE_BITS;
         r = u - (q << SINE_BITS);
         if (q[0]) begin
            r = 64'(SINE_ENTRIES) - r;
         end
         x = (r << 30) >> SINE_BITS;
         v = (quarter_sine(x) + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tbl[i] = (q >= 64'd2) ? -SINE_W'(v) : SINE_W'(v);
      end
      return tbl;
   endfunction

   function automatic step_table_type build_step_table();
      step_table_type tbl;
      logic [63:0] freq;
      logic [63:0] step;
      int n;
      for (int oct = 0; oct <= 10; oct++) begin
         for (int semi = 0; semi < 12; semi++) begin
            n = oct * 12 + semi;
            if (n < NOTE_COUNT) begin
               freq = 64'(TOP_OCTAVE[semi]) >> (10 - oct);
               step = udiv64((freq << PHASE_BITS) + STEP_HALF, STEP_DEN);
               tbl[n] = step[PHASE_BITS-1:0];
            end
         end
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam step_table_type STEP_TABLE = build_step_table();

endpackage

@@ hdl/fmv_sine_rom.sv @@
module fmv_sine_rom import fmv_pkg::*; (
   input  logic                 clock,
   input  logic [SINE_BITS-1:0] addr,
   output sine_type             q
);

   sine_type q_ff;

   always_ff @(posedge clock) begin
      q_ff <= SINE_TABLE[addr];
   end

   assign q = q_ff;

endmodule

@@ hdl/fmv_datapath.sv @@
module fmv_datapath import fmv_pkg::*; (
   input  logic                  clock,
   input  ctrl_type              ctrl,
   input  logic [6:0]            note,
   input  logic [AMP_BITS-1:0]   amplitude,
   input  logic [RATIO_BITS-1:0] mod_ratio,
   input  logic [DEPTH_BITS-1:0] mod_depth,
   output logic signed [15:0]    sample
);

   phase_type voice_mem [VOICE_WORDS];
   phase_type rdata_ff;
   phase_type mp_ff;
   phase_type cp_ff;
   phase_type step_ff;
   logic [OFF_BITS-1:0] mag_ff;
   logic neg_s_ff;
   logic neg_c_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [QUOT_BITS-1:0] quot_ff;

   sine_type rom_q;
   logic [SINE_BITS-1:0] rom_addr;
   logic [MAG_BITS-1:0] s_mag;
   logic [OFF_BITS+PHASE_BITS-1:0] off_wide;
   phase_type off;
   phase_type arg;
   phase_type sum;
   phase_type wdata;
   logic [PHASE_BITS+RATIO_BITS:0] ratio_prod;
   logic [OFF_BITS-1:0] mag_in;
   logic [PROD_BITS-1:0] prod_in;
   logic [DIV_BITS-1:0] quot_wide;
   logic [PROD_BITS-1:0] rem;
   logic [QUOT_BITS-1:0] y;
   logic [15:0] y_ext;

   fmv_sine_rom u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .q     (rom_q)
   );

   always_comb begin
      s_mag = rom_q[SINE_W-1] ? MAG_BITS'(-rom_q) : MAG_BITS'(rom_q);
      off_wide = {mag_ff, {PHASE_BITS{1'b0}}} >> DEPTH_SHIFT;
      off = off_wide[PHASE_BITS-1:0];
      arg = neg_s_ff ? (cp_ff - off) : (cp_ff + off);
      rom_addr = (ctrl.rom_sel == ROM_CAR) ? arg[PHASE_BITS-1 -: SINE_BITS]
                                            : rdata_ff[PHASE_BITS-1 -: SINE_BITS];
      sum = ((ctrl.wr_addr == VA_MOD_PHASE) ? mp_ff : cp_ff) + rdata_ff;
      ratio_prod = (PHASE_BITS+RATIO_BITS+1)'(step_ff)
                   * (PHASE_BITS+RATIO_BITS+1)'(mod_ratio)
                   + (PHASE_BITS+RATIO_BITS+1)'(RATIO_ROUND);
      case (ctrl.wr_sel)
         WD_STEP:     wdata = STEP_TABLE[note];
         WD_MOD_STEP: wdata = ratio_prod[RATIO_FRAC +: PHASE_BITS];
         WD_ZERO:     wdata = '0;
         default:     wdata = sum;
      endcase
      mag_in = OFF_BITS'(mod_depth) * OFF_BITS'(s_mag);
      prod_in = PROD_BITS'(amplitude) * PROD_BITS'(s_mag) + PROD_BITS'(AMP_ROUND);
      quot_wide = DIV_BITS'(prod_ff) * DIV_BITS'(DIV_MUL);
      rem = prod_ff - PROD_BITS'(quot_ff) * PROD_BITS'(AMP_FULL);
      y = quot_ff + QUOT_BITS'(rem >= PROD_BITS'(AMP_FULL));
      y_ext = {1'b0, y};
      sample = neg_c_ff ? -y_ext : y_ext;
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         voice_mem[ctrl.wr_addr] <= wdata;
      end
      rdata_ff <= voice_mem[ctrl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_mp) begin
         mp_ff <= rdata_ff;
      end
      if (ctrl.ld_mix) begin
         cp_ff <= rdata_ff;
         mag_ff <= mag_in;
         neg_s_ff <= rom_q[SINE_W-1];
      end
      if (ctrl.ld_prod) begin
         prod_ff <= prod_in;
         neg_c_ff <= rom_q[SINE_W-1];
      end
      if (ctrl.ld_quot) begin
         quot_ff <= quot_wide[DIV_SHIFT +: QUOT_BITS];
      end
      if (ctrl.ld_step) begin
         step_ff <= STEP_TABLE[note];
      end
   end

endmodule

@@ hdl/fm_voice_oscillator.sv @@
// Two-operator FM voice.
// Input channel req_*: cmd selects sample tick, note on (note, velocity),
// note off or end voice. Only a sample tick yields a result on rsp_*:
// sample (signed Q1.15), gate (key held) and voice_on (voice sounding).
// Configuration: csr_wr_en with csr_index 0 writes mod_ratio (Q4.12),
// index 1 writes mod_depth; other indexes are ignored. Write only while idle.
// Steps after the transfer of a request, which is taken only in idle:
//   sounding tick: TICK_MP, TICK_CP, TICK_MS, TICK_CS, TICK_DIV, TICK_OUT
//   silent tick:   TICK_OUT only; both ticks load the result there, then idle
//   note on:       NOTE_CS to NOTE_MP (four voice-memory writes), then idle
//   note off, end: next request in the following cycle
// The sequence is set by the voice memory (phases and steps; one read and one
// write port) and the single sine ROM, both read through a register, in turn.
// The result sits in an output register; the next request is taken while it
// waits. If rsp_ready stays low, a new tick holds in its last stage until the
// register frees. Reset clears the flags, loads the register reset values and
// returns to idle; the voice memory needs no clearing since every word is
// written on note on before any tick reads it.
module fm_voice_oscillator import fmv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [6:0]         req_note,
   input  logic [6:0]         req_velocity,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_gate,
   output logic               rsp_voice_on,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_TICK_MP  = 11'b000_0000_0010,
      ST_TICK_CP  = 11'b000_0000_0100,
      ST_TICK_MS  = 11'b000_0000_1000,
      ST_TICK_CS  = 11'b000_0001_0000,
      ST_TICK_DIV = 11'b000_0010_0000,
      ST_TICK_OUT = 11'b000_0100_0000,
      ST_NOTE_CS  = 11'b000_1000_0000,
      ST_NOTE_MS  = 11'b001_0000_0000,
      ST_NOTE_CP  = 11'b010_0000_0000,
      ST_NOTE_MP  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic key_held_ff, key_held_in;
   logic sounding_ff, sounding_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RATIO_BITS-1:0] mod_ratio_ff;
   logic [DEPTH_BITS-1:0] mod_depth_ff;
   logic [AMP_BITS-1:0] amplitude_ff;
   logic [6:0] note_ff;
   logic signed [15:0] rsp_sample_ff;
   logic rsp_gate_ff;
   logic rsp_voice_on_ff;

   logic req_xfer;
   logic out_free;
   logic out_load;
   logic note_load;
   ctrl_type ctrl;
   logic signed [15:0] dp_sample;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == ST_TICK_OUT) && out_free;
   assign note_load = req_xfer && (req_cmd == CMD_NOTE_ON);

   always_comb begin
      state_in = state_ff;
      key_held_in = key_held_ff;
      sounding_in = sounding_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (cmd_type'(req_cmd))
                  CMD_TICK: begin
                     state_in = sounding_ff ? ST_TICK_MP : ST_TICK_OUT;
                  end
                  CMD_NOTE_ON: begin
                     key_held_in = 1'b1;
                     sounding_in = 1'b1;
                     state_in = ST_NOTE_CS;
                  end
                  CMD_NOTE_OFF: begin
                     key_held_in = 1'b0;
                  end
                  default: begin
                     key_held_in = 1'b0;
                     sounding_in = 1'b0;
                  end
               endcase
            end
         end
         ST_TICK_MP:  state_in = ST_TICK_CP;
         ST_TICK_CP:  state_in = ST_TICK_MS;
         ST_TICK_MS:  state_in = ST_TICK_CS;
         ST_TICK_CS:  state_in = ST_TICK_DIV;
         ST_TICK_DIV: state_in = ST_TICK_OUT;
         ST_TICK_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_NOTE_CS:  state_in = ST_NOTE_MS;
         ST_NOTE_MS:  state_in = ST_NOTE_CP;
         ST_NOTE_CP:  state_in = ST_NOTE_MP;
         ST_NOTE_MP:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.rd_addr = VA_MOD_PHASE;
      ctrl.wr_sel = WD_SUM;
      ctrl.rom_sel = ROM_MOD;
      unique case (state_ff)
         ST_TICK_MP: begin
            ctrl.ld_mp = 1'b1;
            ctrl.rd_addr = VA_CAR_PHASE;
         end
         ST_TICK_CP: begin
            ctrl.ld_mix = 1'b1;
            ctrl.rd_addr = VA_MOD_STEP;
         end
         ST_TICK_MS: begin
            ctrl.rom_sel = ROM_CAR;
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_MOD_PHASE;
            ctrl.rd_addr = VA_CAR_STEP;
         end
         ST_TICK_CS: begin
            ctrl.ld_prod = 1'b1;
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_CAR_PHASE;
         end
         ST_TICK_DIV: begin
            ctrl.ld_quot = 1'b1;
         end
         ST_NOTE_CS: begin
            ctrl.ld_step = 1'b1;
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_CAR_STEP;
            ctrl.wr_sel = WD_STEP;
         end
         ST_NOTE_MS: begin
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_MOD_STEP;
            ctrl.wr_sel = WD_MOD_STEP;
         end
         ST_NOTE_CP: begin
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_CAR_PHASE;
            ctrl.wr_sel = WD_ZERO;
         end
         ST_NOTE_MP: begin
            ctrl.wr_en = 1'b1;
            ctrl.wr_addr = VA_MOD_PHASE;
            ctrl.wr_sel = WD_ZERO;
            ctrl.rd_addr = VA_CAR_PHASE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_held_ff <= 1'b0;
         sounding_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mod_ratio_ff <= MOD_RATIO_RESET;
         mod_depth_ff <= MOD_DEPTH_RESET;
      end else begin
         state_ff <= state_in;
         key_held_ff <= key_held_in;
         sounding_ff <= sounding_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MOD_RATIO: mod_ratio_ff <= csr_wdata;
               CSR_MOD_DEPTH: mod_depth_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (note_load) begin
         amplitude_ff <= req_velocity;
         note_ff <= req_note;
      end
      if (out_load) begin
         rsp_sample_ff <= sounding_ff ? dp_sample : '0;
         rsp_gate_ff <= key_held_ff;
         rsp_voice_on_ff <= sounding_ff;
      end
   end

   fmv_datapath u_datapath (
      .clock     (clock),
      .ctrl      (ctrl),
      .note      (note_ff),
      .amplitude (amplitude_ff),
      .mod_ratio (mod_ratio_ff),
      .mod_depth (mod_depth_ff),
      .sample    (dp_sample)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_gate = rsp_gate_ff;
   assign rsp_voice_on = rsp_voice_on_ff;

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_voice_on_ff) |-> (rsp_sample_ff == '0))
      else $error("silent voice transfers a nonzero sample");

   a_note_on_start: assert property (@(posedge clock) disable iff (reset)
      note_load |=> (state_ff == ST_NOTE_CS && sounding_ff && key_held_ff))
      else $error("note on did not start the voice");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_TICK_OUT))
      else $error("result raised outside the output stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_OUT && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == ST_TICK_OUT))
      else $error("tick left the output stage while the receiver stalls");

   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.wr_en && ctrl.rd_addr == ctrl.wr_addr))
      else $error("voice memory read and write hit the same word");

endmodule

@@ tb/sv/fm_voice_oscillator_test.sv @@
module fm_voice_oscillator_test;
   import fmv_pkg::*;

   localparam int ROM_SIZE = 1024;
   localparam int ROM_BITS = 10;
   localparam int PH_BITS = 32;
   localparam int AUDIO_RATE = 48000;
   localparam int SETTLE = 20;
   localparam int LONG_HOLD = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 230;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // top octave (notes 120..131) in Hz, Q16.16
   localparam logic [31:0] HZ_TOP [12] = '{
      32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
      32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
      32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748354
   };

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] note;
      logic [6:0] velocity;
   } voice_req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               gate;
      logic               voice_on;
   } voice_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_cmd = CMD_TICK;
   logic [6:0]         req_note = '0;
   logic [6:0]         req_velocity = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample;
   logic               rsp_gate;
   logic               rsp_voice_on;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = CSR_MOD_RATIO;
   logic [15:0]        csr_wdata = '0;

   fm_voice_oscillator i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_note     (req_note),
      .req_velocity (req_velocity),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample),
      .rsp_gate     (rsp_gate),
      .rsp_voice_on (rsp_voice_on),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // voice model state
   logic signed [15:0] sin_rom [ROM_SIZE];
   logic [31:0] car_phase, fm_phase, car_inc, fm_inc;
   logic [6:0]  level;
   logic        key_down, voice_live;
   logic [15:0] ratio_q12 = MOD_RATIO_RESET;
   logic [15:0] depth = MOD_DEPTH_RESET;

   voice_req_type command_queue[$];
   voice_rsp_type expected_samples[$];
   voice_req_type in_flight;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_orders = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int quiet = 0;
   int n_cmds = 0;
   int n_note_on = 0;
   int n_results = 0;
   int n_live = 0;
   int n_settings = 1;

   function automatic logic [63:0] quarter_wave(input logic [63:0] x);
      logic [63:0] xx;
      logic [63:0] acc;
      xx = (x * x) >> 30;
      acc = 64'd85569278 - ((xx * 64'd4858467) >> 30);
      acc = 64'd693598671 - ((xx * acc) >> 30);
      acc = 64'd1686629713 - ((xx * acc) >> 30);
      return (x * acc) >> 30;
   endfunction

   function automatic logic signed [15:0] rom_at(input logic [31:0] ph);
      return sin_rom[ph[PH_BITS-1 -: ROM_BITS]];
   endfunction

   // advances the voice by one accepted command; ticks queue a result
   task automatic voice_step(input voice_req_type r);
      logic [63:0] freq, den, inc64, prod, mag;
      logic [31:0] off, arg;
      logic signed [15:0] s, c;
      int c_mag, y, n;
      voice_rsp_type o;
      n_cmds++;
      case (r.cmd)
         CMD_NOTE_ON: begin
            n = r.note;
            freq = 64'(HZ_TOP[n % 12]) >> (10 - n / 12);
            den = 64'(AUDIO_RATE) << 16;
            inc64 = ((freq << PH_BITS) + den / 2) / den;
            car_inc = inc64[31:0];
            prod = 64'(car_inc) * 64'(ratio_q12) + 64'd2048;
            fm_inc = prod[43:12];
            level = r.velocity;
            car_phase = '0;
            fm_phase = '0;
            key_down = 1'b1;
            voice_live = 1'b1;
            n_note_on++;
         end
         CMD_NOTE_OFF: key_down = 1'b0;
         CMD_END: begin
            key_down = 1'b0;
            voice_live = 1'b0;
         end
         default: begin
            o.gate = key_down;
            o.voice_on = voice_live;
            o.sample = '0;
            if (voice_live) begin
               s = rom_at(fm_phase);
               mag = 64'(depth) * 64'((s < 0) ? -int'(s) : int'(s));
               off = 32'((mag << PH_BITS) >> 31);
               arg = (s < 0) ? car_phase - off : car_phase + off;
               c = rom_at(arg);
               c_mag = (c < 0) ? -int'(c) : int'(c);
               y = (int'(level) * c_mag + 63) / 127;
               o.sample = (c < 0) ? 16'(-y) : 16'(y);
               car_phase = car_phase + car_inc;
               fm_phase = fm_phase + fm_inc;
               n_live++;
            end
            expected_samples.push_back(o);
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            voice_step(in_flight);
         end
         if (!req_valid || req_ready) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = command_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= in_flight.cmd;
               req_note <= in_flight.note;
               req_velocity <= in_flight.velocity;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      voice_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_samples.size() == 0) begin
               $error("unexpected result transfer: sample %0d gate %0b voice_on %0b",
                      rsp_sample, rsp_gate, rsp_voice_on);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
                  errors++;
               end
               if (rsp_gate !== want.gate) begin
                  $error("gate: expected %0b, got %0b", want.gate, rsp_gate);
                  errors++;
               end
               if (rsp_voice_on !== want.voice_on) begin
                  $error("voice_on: expected %0b, got %0b", want.voice_on, rsp_voice_on);
                  errors++;
               end
            end
         end
         if (hold_orders != hold_seen) begin
            hold_seen = hold_orders;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push_cmd(input cmd_type c, input logic [6:0] nt, input logic [6:0] vel);
      command_queue.push_back('{cmd: c, note: nt, velocity: vel});
   endtask

   function automatic logic [6:0] pick_field();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return 7'd0;
      end else if (r == 1) begin
         return 7'd127;
      end
      return 7'($urandom_range(127));
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MOD_RATIO: ratio_q12 = val;
         CSR_MOD_DEPTH: depth = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (command_queue.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // mostly note-on followed by a run of ticks, with releases and ends; some noise
   task automatic queue_random(input int count);
      int made, ticks, cut, k;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) < 8) begin
            push_cmd(CMD_NOTE_ON, pick_field(), pick_field());
            made++;
            ticks = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
            cut = ($urandom_range(3) == 0) ? $urandom_range(ticks - 1) : -1;
            for (k = 0; k < ticks; k++) begin
               if (k == cut) begin
                  push_cmd(CMD_NOTE_OFF, pick_field(), pick_field());
                  made++;
               end
               push_cmd(CMD_TICK, pick_field(), pick_field());
               made++;
            end
            case ($urandom_range(2))
               0: begin
                  push_cmd(CMD_END, pick_field(), pick_field());
                  push_cmd(CMD_TICK, pick_field(), pick_field());
                  made += 2;
               end
               1: begin
                  push_cmd(CMD_NOTE_OFF, pick_field(), pick_field());
                  push_cmd(CMD_TICK, pick_field(), pick_field());
                  made += 2;
               end
               default: ;
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) begin
               push_cmd(cmd_type'($urandom_range(3)), pick_field(), pick_field());
               made++;
            end
         end
      end
   endtask

   initial begin
      int i, quad, pos, ph;
      logic [63:0] mag;
      for (i = 0; i < ROM_SIZE; i++) begin
         quad = (i * 4) / ROM_SIZE;
         pos = (i * 4) % ROM_SIZE;
         if (quad % 2 == 1) begin
            pos = ROM_SIZE - pos;
         end
         mag = (quarter_wave((64'(pos) << 30) / 64'(ROM_SIZE)) + 64'd16384) >> 15;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         sin_rom[i] = (quad >= 2) ? -16'(mag) : 16'(mag);
      end
      car_phase = '0;
      fm_phase = '0;
      car_inc = '0;
      fm_inc = '0;
      level = '0;
      key_down = 1'b0;
      voice_live = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: silent voice, note and velocity extremes, release, end, retrigger
      push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_OFF, 7'd0, 7'd0);
      push_cmd(CMD_END, 7'd0, 7'd0);
      push_cmd(CMD_TICK, 7'd127, 7'd127);
      push_cmd(CMD_NOTE_ON, 7'd0, 7'd127);
      repeat (3) push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_ON, 7'd127, 7'd1);
      repeat (2) push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_ON, 7'd69, 7'd0);
      push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_ON, 7'd60, 7'd100);
      push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_OFF, 7'd0, 7'd0);
      repeat (2) push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_END, 7'd0, 7'd0);
      push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_ON, 7'd127, 7'd127);
      repeat (2) push_cmd(CMD_TICK, 7'd0, 7'd0);
      push_cmd(CMD_NOTE_ON, 7'd85, 7'd42);
      push_cmd(CMD_TICK, 7'd42, 7'd85);
      wait_drained();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_MOD_RATIO, 16'd0);
               write_csr(CSR_MOD_DEPTH, 16'd0);
            end
            1: begin
               write_csr(CSR_MOD_RATIO, 16'hFFFF);
               write_csr(CSR_MOD_DEPTH, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_MOD_RATIO, MOD_RATIO_RESET);
               write_csr(CSR_MOD_DEPTH, MOD_DEPTH_RESET);
               write_csr(CSR_SPARE_A, 16'($urandom_range(65535)));
               write_csr(CSR_SPARE_B, 16'($urandom_range(65535)));
            end
            3: begin
               write_csr(CSR_MOD_RATIO, 16'($urandom_range(65535)));
               write_csr(CSR_MOD_DEPTH, 16'($urandom_range(65535)));
            end
            4: begin
               write_csr(CSR_MOD_RATIO, 16'd4096);
               write_csr(CSR_MOD_DEPTH, 16'hFFFF);
            end
            default: begin
               write_csr(CSR_MOD_RATIO, 16'($urandom_range(65535)));
               write_csr(CSR_MOD_DEPTH, 16'($urandom_range(4096)));
            end
         endcase
         n_settings++;
         @(negedge clock);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         queue_random(PHASE_ITEMS);
         if (ph == 2) begin
            // receiver holds off while the sender keeps offering
            hold_orders++;
         end
         wait_drained();
      end

      if (expected_samples.size() != 0) begin
         $error("%0d expected results never arrived", expected_samples.size());
         errors++;
      end
      $display("Run: %0d commands, %0d note-ons, %0d results (%0d from a sounding voice)",
               n_cmds, n_note_on, n_results, n_live);
      $display("Run: %0d register settings, idle and stall mixes plus one long output hold",
               n_settings);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ fm_voice_oscillator.f @@
hdl/fmv_pkg.sv
hdl/fmv_sine_rom.sv
hdl/fmv_datapath.sv
hdl/fm_voice_oscillator.sv
tb/sv/fm_voice_oscillator_test.sv
